// ===== rtl/hbdt_pkg.sv =====
// Shared types, constants and helpers of the half-bridge dead-time controller.
// Used by hbdt_core, hbdt_out_buf and half_bridge_dead_time_control_top; no dependencies.
package hbdt_pkg;

  // Field widths
  localparam int unsigned CmdW     = 3;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DeadW    = 16;
  localparam int unsigned SpeedW   = 7;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Packed stream widths, rounded up to whole bytes
  localparam int unsigned InBits   = CmdW + TimeW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits  = DutyW + 1 + 1 + PhaseW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  // Register reset values
  localparam logic [DeadW-1:0]  OnDeadRst    = 16'd10;
  localparam logic [DeadW-1:0]  OffDeadRst   = 16'd10;
  localparam logic [DeadW-1:0]  MaxCycleRst  = 16'd1000;
  localparam logic [SpeedW-1:0] SpeedRst     = 7'd100;
  localparam logic [DutyW-1:0]  DutyFull     = 8'd255;

  // speed*255/100 as speed * (255*5243) >> 19; exact for every 7-bit speed
  localparam int unsigned       DutyMulW   = 21;
  localparam logic [DutyMulW-1:0] DutyMul  = 21'd1336965;
  localparam int unsigned       DutyShift  = 19;
  localparam int unsigned       DutyProdW  = SpeedW + DutyMulW;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ON_DEAD   = 3'd0,
    REG_OFF_DEAD  = 3'd1,
    REG_MAX_CYCLE = 3'd2,
    REG_SPEED     = 3'd3,
    REG_ANTI_JAM  = 3'd4
  } reg_idx_e;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_PROCESS   = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_RESET_JAM = 3'd3,
    CMD_HEARTBEAT = 3'd4
  } cmd_e;

  // Bridge phases
  typedef enum logic [PhaseW-1:0] {
    PH_STOP = 2'd0,
    PH_RUN  = 2'd1,
    PH_DEAD = 2'd2
  } phase_e;

  // One result item, packed with run_duty in the lowest bits
  typedef struct packed {
    phase_e           phase;
    logic             jammed;
    logic             brake_on;
    logic [DutyW-1:0] run_duty;
  } result_t;

  // Run duty for a speed setting, saturated at full on
  function automatic logic [DutyW-1:0] duty_for_speed(input logic [SpeedW-1:0] speed);
    logic [DutyProdW-1:0] prod;
    logic [DutyProdW-1:0] quot;
    prod = DutyProdW'(speed) * DutyProdW'(DutyMul);
    quot = prod >> DutyShift;
    if (quot > DutyProdW'(DutyFull)) begin
      return DutyFull;
    end
    return quot[DutyW-1:0];
  endfunction

endpackage

// ===== rtl/hbdt_core.sv =====
// Controller state and configuration registers of the half-bridge dead-time controller.
// Depends on hbdt_pkg; one command is applied per accepted request.
module hbdt_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hbdt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hbdt_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          cmd_valid_i,
  input  logic [hbdt_pkg::CmdW-1:0]     cmd_i,
  input  logic [hbdt_pkg::TimeW-1:0]    now_ms_i,
  output hbdt_pkg::result_t             result_o
);

  // Configuration registers
  logic [hbdt_pkg::DeadW-1:0]  on_dead_q;
  logic [hbdt_pkg::DeadW-1:0]  off_dead_q;
  logic [hbdt_pkg::DeadW-1:0]  max_cycle_q;
  logic [hbdt_pkg::DutyW-1:0]  run_duty_cfg_q;
  logic                        anti_jam_q;

  // Controller state
  logic                        run_req_q, run_req_d;
  logic                        seen_req_q, seen_req_d;
  hbdt_pkg::phase_e            phase_q, phase_d;
  logic [hbdt_pkg::TimeW-1:0]  dead_start_q, dead_start_d;
  logic [hbdt_pkg::DeadW-1:0]  dead_len_q, dead_len_d;
  logic [hbdt_pkg::TimeW-1:0]  last_hb_q, last_hb_d;
  logic                        jam_q, jam_d;
  logic                        run_sw_q, run_sw_d;
  logic                        brake_sw_q, brake_sw_d;
  logic [hbdt_pkg::DutyW-1:0]  duty_q, duty_d;
  logic                        brake_q, brake_d;

  logic [hbdt_pkg::TimeW-1:0]  dead_elapsed;
  logic [hbdt_pkg::TimeW-1:0]  hb_elapsed;
  logic                        dead_over;
  logic                        hb_late;

  // Wrapping time differences
  assign dead_elapsed = now_ms_i - dead_start_q;
  assign hb_elapsed   = now_ms_i - last_hb_q;
  assign dead_over    = dead_elapsed > hbdt_pkg::TimeW'(dead_len_q);
  assign hb_late      = hb_elapsed > hbdt_pkg::TimeW'(max_cycle_q);

  // Next state for the command in hand
  always_comb begin
    run_req_d    = run_req_q;
    seen_req_d   = seen_req_q;
    phase_d      = phase_q;
    dead_start_d = dead_start_q;
    dead_len_d   = dead_len_q;
    last_hb_d    = last_hb_q;
    jam_d        = jam_q;
    run_sw_d     = run_sw_q;
    brake_sw_d   = brake_sw_q;
    duty_d       = duty_q;
    brake_d      = brake_q;

    case (hbdt_pkg::cmd_e'(cmd_i))
      hbdt_pkg::CMD_PROCESS: begin
        if (seen_req_q != run_req_q) begin
          // A changed request opens a dead time; levels stay until the next process
          phase_d      = hbdt_pkg::PH_DEAD;
          dead_len_d   = run_req_q ? on_dead_q : off_dead_q;
          dead_start_d = now_ms_i;
          seen_req_d   = run_req_q;
        end else begin
          case (phase_q)
            hbdt_pkg::PH_DEAD: begin
              duty_d     = '0;
              run_sw_d   = 1'b0;
              brake_d    = 1'b0;
              brake_sw_d = 1'b0;
              if (dead_over) begin
                phase_d = run_req_q ? hbdt_pkg::PH_RUN : hbdt_pkg::PH_STOP;
              end
            end
            hbdt_pkg::PH_RUN: begin
              if (!brake_sw_q) begin
                if (jam_q) begin
                  duty_d  = '0;
                  brake_d = 1'b0;
                end else if (anti_jam_q && hb_late) begin
                  duty_d  = '0;
                  brake_d = 1'b0;
                  jam_d   = 1'b1;
                end else begin
                  jam_d      = 1'b0;
                  brake_d    = 1'b0;
                  brake_sw_d = 1'b0;
                  duty_d     = run_duty_cfg_q;
                  run_sw_d   = 1'b1;
                end
              end
            end
            hbdt_pkg::PH_STOP: begin
              if (!run_sw_q) begin
                duty_d     = '0;
                run_sw_d   = 1'b0;
                brake_d    = 1'b1;
                brake_sw_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      hbdt_pkg::CMD_START: begin
        run_req_d = 1'b1;
        last_hb_d = now_ms_i;
      end
      hbdt_pkg::CMD_STOP: begin
        run_req_d = 1'b0;
      end
      hbdt_pkg::CMD_RESET_JAM: begin
        jam_d = 1'b0;
      end
      hbdt_pkg::CMD_HEARTBEAT: begin
        last_hb_d = now_ms_i;
      end
      default: begin
      end
    endcase
  end

  // Result after the command has been applied
  assign result_o = '{phase:    phase_d,
                      jammed:   jam_d,
                      brake_on: brake_d,
                      run_duty: duty_d};

  // State and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_dead_q      <= hbdt_pkg::OnDeadRst;
      off_dead_q     <= hbdt_pkg::OffDeadRst;
      max_cycle_q    <= hbdt_pkg::MaxCycleRst;
      run_duty_cfg_q <= hbdt_pkg::duty_for_speed(hbdt_pkg::SpeedRst);
      anti_jam_q     <= 1'b1;
      run_req_q      <= 1'b0;
      seen_req_q     <= 1'b0;
      phase_q        <= hbdt_pkg::PH_STOP;
      dead_start_q   <= '0;
      dead_len_q     <= '0;
      last_hb_q      <= '0;
      jam_q          <= 1'b0;
      run_sw_q       <= 1'b0;
      brake_sw_q     <= 1'b0;
      duty_q         <= '0;
      brake_q        <= 1'b0;
    end else begin
      if (cmd_valid_i) begin
        run_req_q    <= run_req_d;
        seen_req_q   <= seen_req_d;
        phase_q      <= phase_d;
        dead_start_q <= dead_start_d;
        dead_len_q   <= dead_len_d;
        last_hb_q    <= last_hb_d;
        jam_q        <= jam_d;
        run_sw_q     <= run_sw_d;
        brake_sw_q   <= brake_sw_d;
        duty_q       <= duty_d;
        brake_q      <= brake_d;
      end
      // The user must write configuration only while no request is in flight; the block does not enforce it
      if (cfg_we_i) begin
        case (hbdt_pkg::reg_idx_e'(cfg_idx_i))
          hbdt_pkg::REG_ON_DEAD:   on_dead_q   <= cfg_wdata_i[hbdt_pkg::DeadW-1:0];
          hbdt_pkg::REG_OFF_DEAD:  off_dead_q  <= cfg_wdata_i[hbdt_pkg::DeadW-1:0];
          hbdt_pkg::REG_MAX_CYCLE: max_cycle_q <= cfg_wdata_i[hbdt_pkg::DeadW-1:0];
          hbdt_pkg::REG_SPEED: begin
            run_duty_cfg_q <= hbdt_pkg::duty_for_speed(cfg_wdata_i[hbdt_pkg::SpeedW-1:0]);
          end
          hbdt_pkg::REG_ANTI_JAM: begin
            anti_jam_q <= cfg_wdata_i[0];
            if (!cfg_wdata_i[0]) begin
              jam_q <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/hbdt_out_buf.sv =====
// Result register with a skid stage for the half-bridge dead-time controller.
// Depends on hbdt_pkg for the result type.
module hbdt_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hbdt_pkg::result_t push_data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output hbdt_pkg::result_t data_o
);

  hbdt_pkg::result_t main_q;
  hbdt_pkg::result_t skid_q;
  logic              main_vld_q;
  logic              skid_vld_q;
  logic              pop;

  // Upstream stalls only once the skid stage holds a request
  assign ready_o = !skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;
  assign pop     = main_vld_q && pop_ready_i;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      priority if (push_i && (!main_vld_q || pop)) begin
        main_vld_q <= 1'b1;
      end else if (push_i) begin
        skid_vld_q <= 1'b1;
      end else if (pop) begin
        main_vld_q <= skid_vld_q;
        skid_vld_q <= 1'b0;
      end else begin
        // Neither side moves this cycle.
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    priority if (push_i && (!main_vld_q || pop)) begin
      main_q <= push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end else if (pop && skid_vld_q) begin
      main_q <= skid_q;
    end else begin
      // Both payloads hold.
    end
  end

endmodule

// ===== rtl/half_bridge_dead_time_control_top.sv =====
// Top level of the half-bridge dead-time controller: stream ports and configuration port.
// Depends on hbdt_pkg, hbdt_core and hbdt_out_buf.
//
//   Channel   Direction  Contents
//   s_axis    in         one command request: command, now_ms
//   m_axis    out        one result per command: run_duty, brake_on, jammed, phase
//   cfg       in         register write, index 0..4, taken in the cycle it is raised
//
// Each command is applied in the cycle it is accepted; its result is registered in the
// result register, or in the skid entry while m_axis is stalled. One request per cycle
// is sustained while m_axis_tready is high; the skid entry lets s_axis take one more
// request while m_axis is stalled, and s_axis_tready drops only when both are full.
// Reset is asynchronous, active low, and restores every register but the result payloads to its default.
module half_bridge_dead_time_control_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hbdt_pkg::InDataW-1:0]  s_axis_tdata,   // command[2:0], now_ms[34:3]
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [hbdt_pkg::OutDataW-1:0] m_axis_tdata,   // run_duty[7:0], brake_on[8],
                                                        // jammed[9], phase[11:10]
  // Configuration writes
  input  logic                          cfg_we_i,
  input  logic [hbdt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hbdt_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic              in_accept;
  logic              buf_ready;
  hbdt_pkg::result_t result;
  hbdt_pkg::result_t out_result;

  assign s_axis_tready = buf_ready;
  assign in_accept     = s_axis_tvalid && buf_ready;

  // Controller state
  hbdt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (in_accept),
    .cmd_i       (s_axis_tdata[hbdt_pkg::CmdW-1:0]),
    .now_ms_i    (s_axis_tdata[hbdt_pkg::CmdW +: hbdt_pkg::TimeW]),
    .result_o    (result)
  );

  // Result register and skid stage
  hbdt_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (result),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_result)
  );

  assign m_axis_tdata = hbdt_pkg::OutDataW'(out_result);

endmodule
